// File: design/wsfr_pkg.sv
// Shared types, codes and helpers for the WebSocket frame receiver.
package wsfr_pkg;

  localparam logic [24:0] HARD_LIMIT = 25'h1000000;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;
  localparam logic [3:0] OP_BIN   = 4'h2;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Config register index (byte address bit 2)
  localparam logic CFG_IDX_MAX_LEN = 1'b0;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] kind;
    logic       frame_end;
    logic       message_end;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } result_t;

  function automatic logic [1:0] kind_of(input logic [3:0] op);
    logic [1:0] k;
    k = KIND_DATA;
    if (op == OP_CLOSE) k = KIND_CLOSE;
    else if (op == OP_PING) k = KIND_PING;
    return k;
  endfunction

  function automatic logic op_known(input logic [3:0] op);
    return (op <= OP_BIN) || ((op >= OP_CLOSE) && (op <= OP_PONG));
  endfunction

endpackage

// File: design/wsfr_chan_if.sv
// Valid/ready channel interface carrying one item per handshake.
interface wsfr_chan_if #(
  parameter type T = wsfr_pkg::in_item_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/wsfr_parser.sv
// Frame header/payload parser: state update and result forming per accepted byte.
module wsfr_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        in_byte,
  input  logic [24:0]       max_len,
  output wsfr_pkg::result_t res,
  output logic              halted
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        mask_r, mask_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [24:0] len_r, len_nxt;
  logic        ovf_r, ovf_nxt;    // length bits above bit 24 were seen
  logic [31:0] key_r, key_nxt;
  logic [24:0] pos_r, pos_nxt;
  logic        halted_r, halted_nxt;

  logic [24:0] lim;
  logic [7:0]  key_byte;
  logic [7:0]  unmasked;
  logic        last;
  logic        msg_end;
  logic        ld_go, bp_go, fin_go;

  assign lim      = (max_len > wsfr_pkg::HARD_LIMIT) ? wsfr_pkg::HARD_LIMIT : max_len;
  assign last     = ({1'b0, pos_r} + 26'd1) == {1'b0, len_r};
  assign msg_end  = (op_r <= wsfr_pkg::OP_BIN) && fin_r;
  assign unmasked = in_byte ^ (mask_r ? key_byte : 8'h00);
  assign halted   = halted_r;

  always_comb begin
    unique case (pos_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    op_nxt     = op_r;
    mask_nxt   = mask_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    res        = '0;
    ld_go      = 1'b0;
    bp_go      = 1'b0;
    fin_go     = 1'b0;

    if (acc && !halted_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt = in_byte[7];
          op_nxt  = in_byte[3:0];
          if (!wsfr_pkg::op_known(in_byte[3:0])) begin
            res.vld       = 1'b1;
            res.item.kind = wsfr_pkg::KIND_ERR;
            halted_nxt    = 1'b1;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          mask_nxt = in_byte[7];
          ovf_nxt  = 1'b0;
          if (in_byte[6:0] == wsfr_pkg::LEN7_EXT16) begin
            cnt_nxt   = 3'd1;
            len_nxt   = '0;
            phase_nxt = PH_EXTLEN;
          end else if (in_byte[6:0] == wsfr_pkg::LEN7_EXT64) begin
            cnt_nxt   = 3'd7;
            len_nxt   = '0;
            phase_nxt = PH_EXTLEN;
          end else begin
            len_nxt = {18'b0, in_byte[6:0]};
            ld_go   = 1'b1;
          end
        end
        PH_EXTLEN: begin
          len_nxt = {len_r[16:0], in_byte};
          ovf_nxt = ovf_r | (|len_r[24:17]);
          if (cnt_r == 3'd0) ld_go = 1'b1;
          else cnt_nxt = cnt_r - 3'd1;
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_byte};
          if (cnt_r == 3'd0) bp_go = 1'b1;
          else cnt_nxt = cnt_r - 3'd1;
        end
        PH_PAYLOAD: begin
          if (op_r == wsfr_pkg::OP_CLOSE) begin
            // close: pass the status code bytes, swallow the reason text
            if (pos_r < 25'd2) begin
              res.vld             = 1'b1;
              res.item.out_byte   = unmasked;
              res.item.byte_valid = 1'b1;
              res.item.kind       = wsfr_pkg::KIND_CLOSE;
              res.item.frame_end  = last;
            end else if (last) begin
              res.vld            = 1'b1;
              res.item.kind      = wsfr_pkg::KIND_CLOSE;
              res.item.frame_end = 1'b1;
            end
          end else if (op_r != wsfr_pkg::OP_PONG) begin
            res.vld              = 1'b1;
            res.item.out_byte    = unmasked;
            res.item.byte_valid  = 1'b1;
            res.item.kind        = wsfr_pkg::kind_of(op_r);
            res.item.frame_end   = last;
            res.item.message_end = last && msg_end;
          end
          pos_nxt = pos_r + 25'd1;
          fin_go  = last;
        end
        default: phase_nxt = PH_HDR0;
      endcase

      // length complete: limit check, then key or payload
      if (ld_go) begin
        if (ovf_nxt || (len_nxt > lim)) begin
          res.vld       = 1'b1;
          res.item.kind = wsfr_pkg::KIND_ERR;
          halted_nxt    = 1'b1;
        end else if (mask_nxt) begin
          cnt_nxt   = 3'd3;
          key_nxt   = '0;
          phase_nxt = PH_MASK;
        end else begin
          bp_go = 1'b1;
        end
      end

      if (bp_go) begin
        if (len_nxt == 25'd0) begin
          if (op_r != wsfr_pkg::OP_PONG) begin
            res.vld              = 1'b1;
            res.item.kind        = wsfr_pkg::kind_of(op_r);
            res.item.frame_end   = 1'b1;
            res.item.message_end = msg_end;
          end
          fin_go = 1'b1;
        end else begin
          pos_nxt   = '0;
          phase_nxt = PH_PAYLOAD;
        end
      end

      if (fin_go) begin
        phase_nxt = PH_HDR0;
        if (op_r == wsfr_pkg::OP_CLOSE) halted_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      fin_r    <= 1'b0;
      op_r     <= '0;
      mask_r   <= 1'b0;
      cnt_r    <= '0;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      key_r    <= '0;
      pos_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      op_r     <= op_nxt;
      mask_r   <= mask_nxt;
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// File: design/wsfr_out_buf.sv
// Two-entry result buffer between the parser and the output channel.
module wsfr_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsfr_pkg::out_item_t push_item,
  input  logic                pop,
  output wsfr_pkg::out_item_t head,
  output logic                not_empty,
  output logic                full
);

  wsfr_pkg::out_item_t mem_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          cnt_r;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: design/websocket_frame_receiver.sv
// WebSocket frame receiver top level: config register, parser and result buffer.
// Usage notes:
//  - in_ch takes one received stream byte per item (valid/ready). Bytes are
//    parsed as RFC 6455 frames: header, extended length, masking key, payload.
//  - out_ch gives zero or one result item per input byte: the unmasked payload
//    byte with kind (data, ping, close, error), frame_end and message_end.
//    Header bytes give only errors and empty-frame ends; pong payloads give none.
//  - A result is registered into the buffer as its byte is taken.
//  - Throughput: one byte per cycle with no gap while a buffer entry is free;
//    the parser updates its state once per byte.
//  - in_ch.ready drops only while both buffer entries hold results not yet
//    taken, so a stalled receiver back-pressures the sender once two results
//    wait; it comes back the cycle after the receiver takes one.
//  - After a close frame ends, or after an error result, all further bytes are
//    taken and dropped until reset.
//  - cfg port (APB style, always ready): register 0 at byte address 0 holds
//    max_payload_len (25 bits); values above 16 MiB act as 16 MiB. Write it
//    only while the block is idle.
//  - Reset (rst_n low, synchronous) returns to the first header byte, clears
//    the halt, empties the buffer and sets max_payload_len to 16 MiB.
module websocket_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  wsfr_chan_if.sink   in_ch,
  wsfr_chan_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [24:0]         max_len_r;
  logic                cfg_wr;
  logic                in_acc;
  logic                out_pop;
  logic                buf_full;
  logic                buf_not_empty;
  logic                halted;
  wsfr_pkg::result_t   res;
  wsfr_pkg::out_item_t head;

  // Config register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == wsfr_pkg::CFG_IDX_MAX_LEN) ? {7'b0, max_len_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= wsfr_pkg::HARD_LIMIT;
    end else if (cfg_wr && (cfg_paddr[2] == wsfr_pkg::CFG_IDX_MAX_LEN)) begin
      max_len_r <= cfg_pwdata[24:0];
    end
  end

  // Handshakes: input is held back only by a full result buffer
  assign in_ch.ready  = !buf_full;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = buf_not_empty;
  assign out_ch.data  = head;
  assign out_pop      = out_ch.valid && out_ch.ready;

  wsfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .in_byte (in_ch.data.in_byte),
    .max_len (max_len_r),
    .res     (res),
    .halted  (halted)
  );

  wsfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res.vld),
    .push_item (res.item),
    .pop       (out_pop),
    .head      (head),
    .not_empty (buf_not_empty),
    .full      (buf_full)
  );

`ifndef SYNTHESIS
  // a result is only formed for a byte that fit into the buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> !buf_full)
    else $error("result pushed into full buffer");

  // an error result always stops the parser
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && (res.item.kind == wsfr_pkg::KIND_ERR)) |=> halted)
    else $error("error result without halt");

  // once halted, no further results until reset
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halted |-> !res.vld)
    else $error("result produced while halted");

  // error results carry no byte and never end a frame
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && (res.item.kind == wsfr_pkg::KIND_ERR)) |->
      (!res.item.byte_valid && !res.item.frame_end && !res.item.message_end))
    else $error("malformed error result");
`endif

endmodule

// File: verif/websocket_frame_receiver_test.sv
// Self-checking testbench for the WebSocket frame receiver: random framed byte streams.
module websocket_frame_receiver_test;

  // Data opcodes without a name in the package.
  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;

  // max_payload_len is the only register, so it lives at byte address 0.
  localparam logic [2:0] MAX_LEN_ADDR = {wsfr_pkg::CFG_IDX_MAX_LEN, 2'b00};
  localparam logic [24:0] LIMIT_TOP = 25'h1FFFFFF;

  localparam int PHASE_BYTES = 380;  // random bytes per register setting
  localparam int REPORT_MAX  = 10;   // mismatches shown in full
  localparam int SETTLE_CYC  = 4;    // results pass through a registered buffer

  // How a frame header spells its payload length.
  typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  // Where the frame parser stands in the byte stream.
  typedef enum logic [2:0] {AT_HEAD0, AT_HEAD1, AT_EXTLEN, AT_KEY, AT_BODY} parse_at_t;

  // Frame parser mirror plus the queue of results it says are due.
  class ws_rx_scoreboard;
    logic [24:0]         limit;
    parse_at_t           at;
    logic                fin;
    logic [3:0]          opcode;
    logic                masked;
    logic [2:0]          ext_left;
    logic [63:0]         pay_len;
    logic [31:0]         key;
    logic [24:0]         pos;
    logic                stopped;
    wsfr_pkg::out_item_t due[$];
    int                  errors;

    function new();
      limit    = wsfr_pkg::HARD_LIMIT;
      at       = AT_HEAD0;
      fin      = 1'b0;
      opcode   = '0;
      masked   = 1'b0;
      ext_left = '0;
      pay_len  = '0;
      key      = '0;
      pos      = '0;
      stopped  = 1'b0;
      errors   = 0;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= REPORT_MAX) $display("MISMATCH %0t: %s", $time, what);
    endfunction

    function void expect_item(logic [7:0] b, logic v, logic [1:0] k, logic fe, logic me);
      wsfr_pkg::out_item_t r;
      r.out_byte    = b;
      r.byte_valid  = v;
      r.kind        = k;
      r.frame_end   = fe;
      r.message_end = me;
      due.insert(due.size(), r);
    endfunction

    function logic [1:0] frame_kind();
      if (opcode == wsfr_pkg::OP_CLOSE) return wsfr_pkg::KIND_CLOSE;
      if (opcode == wsfr_pkg::OP_PING) return wsfr_pkg::KIND_PING;
      return wsfr_pkg::KIND_DATA;
    endfunction

    // Only data frames with FIN close a message.
    function logic ends_message();
      return (opcode <= wsfr_pkg::OP_BIN) && fin;
    endfunction

    function void raise_error();
      stopped = 1'b1;
      expect_item(8'h00, 1'b0, wsfr_pkg::KIND_ERR, 1'b0, 1'b0);
    endfunction

    function void end_frame();
      at = AT_HEAD0;
      if (opcode == wsfr_pkg::OP_CLOSE) stopped = 1'b1;
    endfunction

    function void open_body();
      if (pay_len == 0) begin
        if (opcode != wsfr_pkg::OP_PONG)
          expect_item(8'h00, 1'b0, frame_kind(), 1'b1, ends_message());
        end_frame();
      end else begin
        pos = '0;
        at  = AT_BODY;
      end
    endfunction

    // Limit applies once the length is whole, before any masking key.
    function void length_known();
      logic [24:0] cap;
      cap = (limit > wsfr_pkg::HARD_LIMIT) ? wsfr_pkg::HARD_LIMIT : limit;
      if (pay_len > {39'd0, cap}) begin
        raise_error();
      end else if (masked) begin
        ext_left = 3'd3;
        key      = '0;
        at       = AT_KEY;
      end else begin
        open_body();
      end
    endfunction

    function void body_byte(logic [7:0] b);
      logic [7:0] v;
      logic       last;
      v = b;
      if (masked) v = b ^ key[(3 - pos[1:0]) * 8 +: 8];
      last = ({39'd0, pos} + 64'd1) == pay_len;
      if (opcode == wsfr_pkg::OP_CLOSE) begin
        // close: status bytes pass, the rest is swallowed but the end is marked
        if (pos < 25'd2) expect_item(v, 1'b1, wsfr_pkg::KIND_CLOSE, last, 1'b0);
        else if (last) expect_item(8'h00, 1'b0, wsfr_pkg::KIND_CLOSE, 1'b1, 1'b0);
      end else if (opcode != wsfr_pkg::OP_PONG) begin
        expect_item(v, 1'b1, frame_kind(), last, last && ends_message());
      end
      pos = pos + 25'd1;
      if (last) end_frame();
    endfunction

    function void take_byte(logic [7:0] b);
      if (stopped) return;
      case (at)
        AT_HEAD0: begin
          fin    = b[7];
          opcode = b[3:0];
          if (!(opcode <= wsfr_pkg::OP_BIN ||
                (opcode >= wsfr_pkg::OP_CLOSE && opcode <= wsfr_pkg::OP_PONG))) begin
            raise_error();
          end else begin
            at = AT_HEAD1;
          end
        end
        AT_HEAD1: begin
          masked  = b[7];
          pay_len = '0;
          if (b[6:0] == wsfr_pkg::LEN7_EXT16) begin
            ext_left = 3'd1;
            at       = AT_EXTLEN;
          end else if (b[6:0] == wsfr_pkg::LEN7_EXT64) begin
            ext_left = 3'd7;
            at       = AT_EXTLEN;
          end else begin
            pay_len = {57'd0, b[6:0]};
            length_known();
          end
        end
        AT_EXTLEN: begin
          pay_len = {pay_len[55:0], b};
          if (ext_left == 0) length_known();
          else ext_left = ext_left - 3'd1;
        end
        AT_KEY: begin
          key = {key[23:0], b};
          if (ext_left == 0) open_body();
          else ext_left = ext_left - 3'd1;
        end
        AT_BODY: body_byte(b);
        default: at = AT_HEAD0;
      endcase
    endfunction

    function void check_result(wsfr_pkg::out_item_t got);
      wsfr_pkg::out_item_t want;
      if (due.size() == 0) begin
        flag($sformatf("result with nothing due: byte %02h bv %0b kind %0d fe %0b me %0b",
                       got.out_byte, got.byte_valid, got.kind, got.frame_end,
                       got.message_end));
        return;
      end
      want = due.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.kind !== want.kind || got.frame_end !== want.frame_end ||
          got.message_end !== want.message_end) begin
        flag($sformatf({"result: want byte %02h bv %0b kind %0d fe %0b me %0b, ",
                        "got byte %02h bv %0b kind %0d fe %0b me %0b"},
                       want.out_byte, want.byte_valid, want.kind, want.frame_end,
                       want.message_end, got.out_byte, got.byte_valid, got.kind,
                       got.frame_end, got.message_end));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  wsfr_chan_if #(.T(wsfr_pkg::in_item_t))  in_ch ();
  wsfr_chan_if #(.T(wsfr_pkg::out_item_t)) out_ch ();

  websocket_frame_receiver u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ws_rx_scoreboard book;
  int              bytes_sent;
  int              send_calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: stops a run that hangs and reports it with errors.
  initial begin
    #20000000;
    $display("websocket_frame_receiver_test: done, errors");
    $finish;
  end

  // Idle draw shared by both sides: mostly busy, sometimes long gaps, and now
  // and then a calm stretch of back-to-back items.
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Both handshakes are seen at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) book.take_byte(in_ch.data.in_byte);
      if (out_ch.valid && out_ch.ready) book.check_result(out_ch.data);
    end
  end

  // Result side: random stall before each item.
  initial begin : result_sink
    int hold;
    int calm;
    out_ch.ready = 1'b0;
    calm = 0;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_wait(calm);
      repeat (hold) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // One stream byte: optional gap, then hold valid until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(send_calm);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.data.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Sender holds off until every due result is out, plus the result latency,
  // so that header bytes still in flight are done too.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] a, input logic [31:0] d);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= a;
    cfg_pwdata  <= d;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (a == MAX_LEN_ADDR) book.limit = d[24:0];
  endtask

  task automatic cfg_expect(input logic [2:0] a, input logic [31:0] want);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= a;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want)
      book.flag($sformatf("register read at %0d: want %h got %h", a, want, cfg_prdata));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Short lengths mostly use the 7-bit field, but the wide forms are legal
  // for any length and get exercised too.
  function automatic len_form_t pick_form(input logic [63:0] len);
    int p;
    if (len <= 125) begin
      p = $urandom_range(0, 5);
      if (p < 4) return LEN_SHORT;
      return (p == 4) ? LEN_EXT16 : LEN_EXT64;
    end
    if (len <= 65535) return ($urandom_range(0, 1) == 0) ? LEN_EXT16 : LEN_EXT64;
    return LEN_EXT64;
  endfunction

  // Header through the length field; reserved bits are random noise.
  task automatic send_head(input logic [3:0] op, input logic fin, input logic masked,
                           input logic [63:0] len, input len_form_t form);
    send_byte({fin, 3'($urandom_range(0, 7)), op});
    case (form)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_EXT16: begin
        send_byte({masked, wsfr_pkg::LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, wsfr_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[i * 8 +: 8]);
      end
    endcase
  endtask

  // Whole frame; a negative fill means random payload.
  task automatic put_frame(input logic [3:0] op, input logic fin, input logic masked,
                           input logic [31:0] key, input logic [63:0] len,
                           input len_form_t form, input int fill);
    send_head(op, fin, masked, len, form);
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[i * 8 +: 8]);
    for (longint n = 0; n < len; n++) send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  // Any frame that keeps the parser running: data, ping or pong, within cap.
  task automatic random_frame(input logic [24:0] cap);
    int          pick;
    logic [3:0]  op;
    logic [63:0] len;
    pick = $urandom_range(0, 9);
    if (pick < 6) op = 4'($urandom_range(0, wsfr_pkg::OP_BIN));
    else if (pick < 8) op = wsfr_pkg::OP_PING;
    else op = wsfr_pkg::OP_PONG;
    pick = $urandom_range(0, 19);
    if (pick < 2) len = 64'd0;
    else if (pick < 16) len = 64'($urandom_range(1, 20));
    else if (pick < 18) len = 64'($urandom_range(100, 200));
    else if (pick < 19) len = 64'($urandom_range(126, 300));
    else len = (cap <= 64) ? {39'd0, cap} : 64'($urandom_range(1, 20));  // at the limit if small
    if (len > {39'd0, cap}) len = 64'($urandom_range(0, cap));
    put_frame(op, 1'($urandom_range(0, 1)), $urandom_range(0, 9) < 7, $urandom, len,
              pick_form(len), -1);
  endtask

  task automatic run_random(input int quota);
    int          start;
    logic [24:0] cap;
    cap   = (book.limit > wsfr_pkg::HARD_LIMIT) ? wsfr_pkg::HARD_LIMIT : book.limit;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      random_frame(cap);
      // full drain now and then, sender stays quiet meanwhile
      if ($urandom_range(0, 14) == 0) settle();
    end
  endtask

  // The block halts for good after a close or an error, and reset comes only
  // once, so the run ends on one of them, picked at random: unknown opcode,
  // length over the limit, or a close frame (often longer than two bytes).
  // Trailing bytes then check that the halted block stays silent.
  task automatic end_stream();
    int          pick;
    logic [3:0]  op;
    logic [24:0] cap;
    logic [63:0] len;
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      pick = $urandom_range(0, 9);
      op = (pick < 5) ? wsfr_pkg::OP_BIN + 4'd1 + 4'(pick)
                      : wsfr_pkg::OP_PONG + 4'd1 + 4'(pick - 5);
      send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op});
    end else if (pick == 1) begin
      if ($urandom_range(0, 1) == 0) begin
        // one past a small limit
        cap = 25'($urandom_range(0, 30));
        settle();
        cfg_write(MAX_LEN_ADDR, {7'd0, cap});
        len = {39'd0, cap} + 64'd1;
      end else begin
        // past the hard cap, often with the top length bytes in use
        len = {$urandom, $urandom} | 64'h0000_0000_0100_0001;
      end
      send_head(4'($urandom_range(0, wsfr_pkg::OP_BIN)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), len, pick_form(len));
    end else begin
      len = 64'($urandom_range(0, 6));
      put_frame(wsfr_pkg::OP_CLOSE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                $urandom, len, pick_form(len), -1);
    end
    repeat (16) send_byte(8'($urandom));
  endtask

  initial begin
    logic [3:0] op;
    int         pick;
    book        = new();
    bytes_sent  = 0;
    send_calm   = 0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the limit, then a few hand-picked frames:
    // empty text frame, all-ones key over zero bytes, continuation with a
    // 16-bit length and all-ones payload, masked ping with a zero key, pong.
    cfg_expect(MAX_LEN_ADDR, {7'd0, wsfr_pkg::HARD_LIMIT});
    put_frame(OP_TEXT, 1'b1, 1'b0, 32'h0, 64'd0, LEN_SHORT, 0);
    put_frame(wsfr_pkg::OP_BIN, 1'b0, 1'b1, 32'hFFFF_FFFF, 64'd2, LEN_SHORT, 8'h00);
    put_frame(OP_CONT, 1'b1, 1'b0, 32'h0, 64'd1, LEN_EXT16, 8'hFF);
    put_frame(wsfr_pkg::OP_PING, 1'b1, 1'b1, 32'h0, 64'd1, LEN_SHORT, 8'h00);
    put_frame(wsfr_pkg::OP_PONG, 1'b1, 1'b0, 32'h0, 64'd2, LEN_SHORT, 8'hFF);
    settle();

    // Limit zero: only empty frames get through.
    cfg_write(MAX_LEN_ADDR, 32'd0);
    cfg_expect(MAX_LEN_ADDR, 32'd0);
    repeat (6) begin
      pick = $urandom_range(0, 4);
      op = (pick <= 2) ? 4'(pick) : ((pick == 3) ? wsfr_pkg::OP_PING : wsfr_pkg::OP_PONG);
      put_frame(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, 64'd0,
                pick_form(64'd0), -1);
    end
    settle();

    // All-ones register value behaves as the hard cap.
    cfg_write(MAX_LEN_ADDR, {7'd0, LIMIT_TOP});
    cfg_expect(MAX_LEN_ADDR, {7'd0, LIMIT_TOP});
    run_random(PHASE_BYTES);
    settle();

    // Small limit, with frames landing exactly on it.
    cfg_write(MAX_LEN_ADDR, 32'($urandom_range(8, 40)));
    run_random(PHASE_BYTES);
    settle();

    cfg_write(MAX_LEN_ADDR, {7'd0, wsfr_pkg::HARD_LIMIT});
    run_random(PHASE_BYTES);

    end_stream();
    settle();

    if (book.errors == 0) begin
      $display("websocket_frame_receiver_test: done, clean");
    end else begin
      $display("websocket_frame_receiver_test: done, errors");
    end
    $finish;
  end

endmodule
